[sv/mdc_pkg.sv]
// Shared types and constants for the mouse double-click detector.
package mdc_pkg;

   localparam int NUM_BUTTONS = 10;
   localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);
   localparam logic [4:0] BTN_LIMIT = 5'(NUM_BUTTONS);
   localparam logic [BTN_IDX_W-1:0] SCAN_FIRST = BTN_IDX_W'(1);
   localparam logic [BTN_IDX_W-1:0] SCAN_LAST  = BTN_IDX_W'(NUM_BUTTONS - 1);

   localparam logic [15:0] WINDOW_RESET   = 16'd300;
   localparam logic [7:0]  DISTANCE_RESET = 8'd2;

   typedef enum logic {
      REG_WINDOW   = 1'b0,
      REG_DISTANCE = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_PRESS       = 2'd0,
      OP_RELEASE     = 2'd1,
      OP_MOTION      = 2'd2,
      OP_RELEASE_ALL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EV_DOWN   = 2'd0,
      EV_DCLICK = 2'd1,
      EV_UP     = 2'd2,
      EV_MOVE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP_T,
      ST_CMP_X,
      ST_CMP_Y,
      ST_EMIT,
      ST_SCAN
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic [31:0]        event_time;
      logic [3:0]         button;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               shift_down;
      logic               alt_down;
      logic               ctrl_down;
   } req_type;

   typedef struct packed {
      kind_type           event_kind;
      logic [31:0]        out_time;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [3:0]         out_button;
      logic [2:0]         modifier_mask;
      logic               last_of_run;
   } rsp_type;

   // Operands for the shared difference and limit compare unit.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] limit;
      logic        abs_mode;
   } cmp_op_type;

endpackage

[sv/mdc_cmp_unit.sv]
// Shared subtract, magnitude and limit compare unit.
module mdc_cmp_unit
   import mdc_pkg::*;
(
   input  cmp_op_type op,
   output logic       in_limit
);

   logic [31:0] diff;
   logic [31:0] mag;

   always_comb begin
      diff = op.a - op.b;
      // Coordinates arrive sign-extended, so the difference fits and its top bit is the sign.
      if (op.abs_mode && diff[31]) begin
         mag = 32'd0 - diff;
      end else begin
         mag = diff;
      end
      in_limit = (mag <= op.limit);
   end

endmodule

[sv/mouse_event_double_click.sv]
// Top level of the mouse double-click detector: sequencer, state and output register.
//
//   channel   ports                        direction   payload
//   request   req_valid/req_ready          in          req_type
//   result    rsp_valid/rsp_ready          out         rsp_type
//   config    csr_we/csr_index/csr_wdata   in          16-bit write data
//
// A press goes through accept, time, x and y compares on the shared unit, then output.
// Release and motion: accept, then output; motion to an unchanged position emits no result.
// Release-all goes through accept, then a scan of button slots 1..9.
// A new request is taken only in the idle state; a result waits in the output register,
// and the output step stalls while that register is still full and not taken.
// Reset is synchronous, clears control and flag registers and restores the register defaults.
module mouse_event_double_click
   import mdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic      match_ff, match_in;
   logic [BTN_IDX_W-1:0] scan_ff, scan_in;
   logic [NUM_BUTTONS-1:0] held_ff, held_in;
   logic        click_valid_ff, click_valid_in;
   logic [3:0]  click_button_ff, click_button_in;
   logic [31:0] click_time_ff, click_time_in;
   logic signed [15:0] click_x_ff, click_x_in;
   logic signed [15:0] click_y_ff, click_y_in;
   logic        ptr_valid_ff, ptr_valid_in;
   logic signed [15:0] ptr_x_ff, ptr_x_in;
   logic signed [15:0] ptr_y_ff, ptr_y_in;
   logic [15:0] window_ff, window_in;
   logic [7:0]  distance_ff, distance_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   cmp_op_type cmp_op;
   logic       cmp_within;
   logic       slot_free;
   logic       motion_same;
   logic       btn_in_range;
   logic       scan_bit;
   logic [NUM_BUTTONS-1:0] held_rest;

   mdc_cmp_unit u_cmp (
      .op       (cmp_op),
      .in_limit (cmp_within)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign motion_same  = ptr_valid_ff && (req_ff.pos_x == ptr_x_ff) && (req_ff.pos_y == ptr_y_ff);
   assign btn_in_range = ({1'b0, req_ff.button} < BTN_LIMIT);
   assign scan_bit     = held_ff[scan_ff];
   assign held_rest    = held_ff >> scan_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation)
                  OP_PRESS:       state_in = ST_CMP_T;
                  OP_RELEASE_ALL: state_in = ST_SCAN;
                  default:        state_in = ST_EMIT;
               endcase
            end
         end
         ST_CMP_T: state_in = ST_CMP_X;
         ST_CMP_X: state_in = ST_CMP_Y;
         ST_CMP_Y: state_in = ST_EMIT;
         ST_EMIT: begin
            if ((req_ff.operation == OP_MOTION && motion_same) || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if ((!scan_bit || slot_free) && scan_ff == SCAN_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_in          = req_ff;
      match_in        = match_ff;
      scan_in         = scan_ff;
      held_in         = held_ff;
      click_valid_in  = click_valid_ff;
      click_button_in = click_button_ff;
      click_time_in   = click_time_ff;
      click_x_in      = click_x_ff;
      click_y_in      = click_y_ff;
      ptr_valid_in    = ptr_valid_ff;
      ptr_x_in        = ptr_x_ff;
      ptr_y_in        = ptr_y_ff;
      window_in       = window_ff;
      distance_in     = distance_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      cmp_op          = '0;

      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_WINDOW:   window_in   = csr_wdata;
            REG_DISTANCE: distance_in = csr_wdata[7:0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               scan_in = SCAN_FIRST;
            end
         end
         ST_CMP_T: begin
            cmp_op.a     = req_ff.event_time;
            cmp_op.b     = click_time_ff;
            cmp_op.limit = {16'd0, window_ff};
            match_in = click_valid_ff && (req_ff.button == click_button_ff) && cmp_within;
         end
         ST_CMP_X: begin
            cmp_op.a        = {{16{req_ff.pos_x[15]}}, req_ff.pos_x};
            cmp_op.b        = {{16{click_x_ff[15]}}, click_x_ff};
            cmp_op.limit    = {24'd0, distance_ff};
            cmp_op.abs_mode = 1'b1;
            match_in = match_ff && cmp_within;
         end
         ST_CMP_Y: begin
            cmp_op.a        = {{16{req_ff.pos_y[15]}}, req_ff.pos_y};
            cmp_op.b        = {{16{click_y_ff[15]}}, click_y_ff};
            cmp_op.limit    = {24'd0, distance_ff};
            cmp_op.abs_mode = 1'b1;
            match_in = match_ff && cmp_within;
         end
         ST_EMIT: begin
            if (!(req_ff.operation == OP_MOTION && motion_same) && slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_time      = req_ff.event_time;
               rsp_data_in.out_x         = req_ff.pos_x;
               rsp_data_in.out_y         = req_ff.pos_y;
               rsp_data_in.out_button    = req_ff.button;
               rsp_data_in.modifier_mask = 3'd0;
               rsp_data_in.last_of_run   = 1'b1;
               unique case (req_ff.operation)
                  OP_PRESS: begin
                     rsp_data_in.event_kind    = match_ff ? EV_DCLICK : EV_DOWN;
                     rsp_data_in.modifier_mask = {req_ff.ctrl_down, req_ff.alt_down,
                                                  req_ff.shift_down};
                     if (btn_in_range) begin
                        held_in[req_ff.button[BTN_IDX_W-1:0]] = 1'b1;
                     end
                     click_valid_in  = 1'b1;
                     click_button_in = req_ff.button;
                     click_time_in   = req_ff.event_time;
                     click_x_in      = req_ff.pos_x;
                     click_y_in      = req_ff.pos_y;
                     ptr_valid_in    = 1'b1;
                     ptr_x_in        = req_ff.pos_x;
                     ptr_y_in        = req_ff.pos_y;
                  end
                  OP_RELEASE: begin
                     rsp_data_in.event_kind = EV_UP;
                     if (btn_in_range) begin
                        held_in[req_ff.button[BTN_IDX_W-1:0]] = 1'b0;
                     end
                  end
                  default: begin
                     rsp_data_in.event_kind = EV_MOVE;
                     rsp_data_in.out_button = 4'd0;
                     ptr_valid_in = 1'b1;
                     ptr_x_in     = req_ff.pos_x;
                     ptr_y_in     = req_ff.pos_y;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_bit && slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.event_kind    = EV_UP;
               rsp_data_in.out_time      = req_ff.event_time;
               rsp_data_in.out_x         = 16'sd0;
               rsp_data_in.out_y         = 16'sd0;
               rsp_data_in.out_button    = 4'(scan_ff);
               rsp_data_in.modifier_mask = 3'd0;
               // Last when no held button remains above the current slot.
               rsp_data_in.last_of_run   = ((held_rest >> 1) == '0);
               held_in[scan_ff]          = 1'b0;
            end
            if (!scan_bit || slot_free) begin
               scan_in = scan_ff + 1'b1;
               if (scan_ff == SCAN_LAST) begin
                  click_valid_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         held_ff        <= '0;
         click_valid_ff <= 1'b0;
         ptr_valid_ff   <= 1'b0;
         window_ff      <= WINDOW_RESET;
         distance_ff    <= DISTANCE_RESET;
         rsp_valid_ff   <= 1'b0;
         match_ff       <= 1'b0;
         scan_ff        <= SCAN_FIRST;
      end else begin
         state_ff       <= state_in;
         held_ff        <= held_in;
         click_valid_ff <= click_valid_in;
         ptr_valid_ff   <= ptr_valid_in;
         window_ff      <= window_in;
         distance_ff    <= distance_in;
         rsp_valid_ff   <= rsp_valid_in;
         match_ff       <= match_in;
         scan_ff        <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      click_button_ff <= click_button_in;
      click_time_ff   <= click_time_in;
      click_x_ff      <= click_x_in;
      click_y_ff      <= click_y_in;
      ptr_x_ff        <= ptr_x_in;
      ptr_y_ff        <= ptr_y_in;
      rsp_data_ff     <= rsp_data_in;
   end

endmodule
